/* design/fsnp_pkg.sv */
// Shared types, character codes and sizes for the format string number printer.
// No dependencies; every other design file imports this package.
package fsnp_pkg;

  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 32;
  localparam int NIB_W      = 4;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = ARG_W / NIB_W;
  localparam int DIGITS_W   = DEC_DIGITS * NIB_W;
  localparam int BIT_CNT_W  = $clog2(ARG_W);
  localparam int REM_W      = $clog2(DEC_DIGITS + 1);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A_LO    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C_LO    = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D_LO    = 8'h64;
  localparam logic [CHAR_W-1:0] CH_D_UP    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_X_LO    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP    = 8'h58;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DEC,
    CMD_HEX
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] chr;
    logic [ARG_W-1:0]  arg;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_EMIT
  } back_state_t;

endpackage

/* design/fsnp_front.sv */
// Front end: accepts format characters, tracks the pending percent, and turns
// each request that prints something into a command. Depends on fsnp_pkg.
module fsnp_front import fsnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [CHAR_W-1:0] format_char,
  input  logic [ARG_W-1:0]  argument,
  input  logic              q_full,
  output logic              full,
  output logic              cmd_push,
  output cmd_t              cmd
);

  logic percent_pending;
  logic percent_pending_next;
  logic accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    percent_pending_next = percent_pending;
    cmd_push             = 1'b0;
    cmd.kind             = CMD_CHAR;
    cmd.chr              = format_char;
    cmd.arg              = argument;
    if (accept) begin
      if (format_char == CH_NUL) begin
        percent_pending_next = 1'b0;
      end else if (percent_pending) begin
        percent_pending_next = 1'b0;
        case (format_char) inside
          CH_PERCENT: begin
            cmd_push = 1'b1;
          end
          CH_C_LO: begin
            cmd.chr  = argument[CHAR_W-1:0];
            cmd_push = (argument[CHAR_W-1:0] != CH_NUL);
          end
          CH_D_LO, CH_D_UP: begin
            cmd.kind = CMD_DEC;
            cmd_push = 1'b1;
          end
          CH_X_LO, CH_X_UP: begin
            cmd.kind = CMD_HEX;
            cmd_push = 1'b1;
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end else if (format_char == CH_PERCENT) begin
        percent_pending_next = 1'b1;
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
    end else begin
      percent_pending <= percent_pending_next;
    end
  end

endmodule

/* design/fsnp_cmd_fifo.sv */
// Two-entry command queue between the front and back ends.
// Depends on fsnp_pkg.
module fsnp_cmd_fifo import fsnp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full   = (count == Q_CNT_W'(Q_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/fsnp_back.sv */
// Back end: runs one command at a time, converting numbers to digits and
// driving the one-entry result register. Depends on fsnp_pkg.
module fsnp_back import fsnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic [CHAR_W-1:0] out_char,
  output logic              last,
  output logic              empty,
  input  logic              pop
);

  back_state_t           state;
  back_state_t           state_next;
  logic [DIGITS_W-1:0]   digits;
  logic [ARG_W-1:0]      bin;
  logic [BIT_CNT_W-1:0]  cnt;
  logic [REM_W-1:0]      rem;
  logic                  started;
  logic                  ovalid;
  logic                  can_emit;
  logic [NIB_W-1:0]      top_nib;
  logic                  skip_zero;
  logic                  load_char;
  logic                  load_dec;
  logic                  load_hex;
  logic                  dd_step;
  logic                  skip;
  logic                  emit_digit;
  logic                  conv_done;
  logic [DIGITS_W-1:0]   digits_adj;

  function automatic logic [DIGITS_W-1:0] add3(input logic [DIGITS_W-1:0] v);
    logic [DIGITS_W-1:0] r;
    r = v;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (v[i*NIB_W +: NIB_W] >= 4'd5) begin
        r[i*NIB_W +: NIB_W] = v[i*NIB_W +: NIB_W] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] nib_char(input logic [NIB_W-1:0] n);
    logic [CHAR_W-1:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {{(CHAR_W-NIB_W){1'b0}}, n};
    end else begin
      r = CH_A_LO + {{(CHAR_W-NIB_W){1'b0}}, n} - CHAR_W'(10);
    end
    return r;
  endfunction

  assign empty      = !ovalid;
  assign can_emit   = !ovalid || pop;
  assign top_nib    = digits[DIGITS_W-1 -: NIB_W];
  assign skip_zero  = (top_nib == '0) && !started && (rem != REM_W'(1));
  assign conv_done  = (cnt == BIT_CNT_W'(ARG_W - 1));
  assign digits_adj = add3(digits);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_DEC) begin
          state_next = B_CONV;
        end else if (!cmd_empty && cmd.kind == CMD_HEX) begin
          state_next = B_EMIT;
        end
      end
      B_CONV: begin
        if (conv_done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!skip_zero && can_emit && rem == REM_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop    = 1'b0;
    load_char  = 1'b0;
    load_dec   = 1'b0;
    load_hex   = 1'b0;
    dd_step    = 1'b0;
    skip       = 1'b0;
    emit_digit = 1'b0;
    case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.kind)
            CMD_CHAR: begin
              cmd_pop   = can_emit;
              load_char = can_emit;
            end
            CMD_DEC: begin
              cmd_pop  = 1'b1;
              load_dec = 1'b1;
            end
            CMD_HEX: begin
              cmd_pop  = 1'b1;
              load_hex = 1'b1;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      B_CONV: begin
        dd_step = 1'b1;
      end
      B_EMIT: begin
        skip       = skip_zero;
        emit_digit = !skip_zero && can_emit;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_char || emit_digit) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_char) begin
      out_char <= cmd.chr;
      last     <= 1'b1;
    end else if (emit_digit) begin
      out_char <= nib_char(top_nib);
      last     <= (rem == REM_W'(1));
    end
    if (load_dec) begin
      bin    <= cmd.arg;
      digits <= '0;
      cnt    <= '0;
    end else if (load_hex) begin
      digits  <= {cmd.arg, {(DIGITS_W-ARG_W){1'b0}}};
      rem     <= REM_W'(HEX_DIGITS);
      started <= 1'b0;
    end else if (dd_step) begin
      {digits, bin} <= {digits_adj, bin} << 1;
      cnt           <= cnt + 1'b1;
      if (conv_done) begin
        rem     <= REM_W'(DEC_DIGITS);
        started <= 1'b0;
      end
    end else if (skip || emit_digit) begin
      digits <= digits << NIB_W;
      rem    <= rem - 1'b1;
      if (emit_digit) begin
        started <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> rem != '0)
    else $error("emit state with no digits left");
  a_last_digit_ends: assert property (@(posedge clk) disable iff (rst)
    emit_digit && rem == REM_W'(1) |=> state == B_IDLE && last)
    else $error("final digit did not end the command");
  a_conv_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == B_CONV && conv_done |=> state == B_EMIT && rem == REM_W'(DEC_DIGITS))
    else $error("conversion did not hand over ten digits");
  a_no_pop_midwork: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> !cmd_pop)
    else $error("command popped while busy");
`endif

endmodule

/* design/format_string_number_printer.sv */
// Top level of the format string number printer.
// Instantiates fsnp_front, fsnp_cmd_fifo and fsnp_back; depends on fsnp_pkg.
//
// Feed format string bytes with push/full, each with its argument word; pull
// printable characters with empty/pop, with last marking the final character
// of each request. A plain byte is echoed, a '%' arms the next byte as a
// conversion ('%', 'c', 'd'/'D' unsigned decimal, 'x'/'X' lowercase hex),
// and a zero byte ends the string and clears any pending '%'. Requests that
// print nothing are absorbed by the front end and never reach the back end.
// Flow: a run of plain characters or %c/%% streams at one per cycle while
// the receiver keeps popping. %x loads, then steps through every nibble,
// leading zeros included but not printed. %d loads, then runs 32 shift-add-3
// steps of the binary-to-BCD converter and then ten digit slots. The back
// end's shared digit shifter handles one conversion at a time; the two-entry
// command queue lets the front end keep accepting while it works, and the
// result register holds a character until it is popped.
module format_string_number_printer import fsnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] format_char,
  input  logic [ARG_W-1:0]  argument,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] out_char,
  output logic              last
);

  logic q_full;
  logic q_empty;
  logic cmd_push;
  logic cmd_pop;
  cmd_t front_cmd;
  cmd_t back_cmd;

  // classify each request and hold the pending percent
  fsnp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .format_char (format_char),
    .argument    (argument),
    .q_full      (q_full),
    .full        (full),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd)
  );

  // decouple the front end from the slow number conversions
  fsnp_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd     (cmd_pop),
    .rd_cmd (back_cmd),
    .empty  (q_empty)
  );

  // convert and emit characters into the result register, one per cycle while it is free or being popped
  fsnp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_char  (out_char),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the format string number printer.
// Depends on fsnp_pkg and format_string_number_printer; predicts every printed
// character in a local model and checks it as it is popped.
module testbench;
  import fsnp_pkg::*;

  // Run length guards. The slowest request is %d: its conversion plus ten
  // characters, each of which may wait out a long receiver stall.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 122;
  localparam int BURST_ITEMS  = 24;

  // One printed character as the block should present it.
  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } print_char_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              push;
  logic              full;
  logic [CHAR_W-1:0] format_char;
  logic [ARG_W-1:0]  argument;
  logic              empty;
  logic              pop = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  // Characters still owed by the block, oldest first.
  print_char_t expected_chars[$];
  // Local copy of the block's '%' armed flag.
  logic        percent_armed = 1'b0;

  int          error_count   = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  logic        holding       = 1'b0;

  format_string_number_printer DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .format_char (format_char),
    .argument    (argument),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last        (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Kill the run, reporting errors, once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Work out what one accepted request prints and queue it. A NUL ends the
  // string and disarms a pending '%'; a conversion after '%' consumes the
  // argument; anything else after '%' prints nothing.
  function automatic void predict_printout(logic [CHAR_W-1:0] ch, logic [ARG_W-1:0] arg);
    logic [CHAR_W-1:0] chars[$];
    logic [ARG_W-1:0]  v;
    logic [NIB_W-1:0]  nib;
    print_char_t       entry;
    v = arg;
    if (ch == CH_NUL) begin
      percent_armed = 1'b0;
      return;
    end
    if (percent_armed) begin
      percent_armed = 1'b0;
      case (ch)
        CH_PERCENT: chars.push_back(CH_PERCENT);
        CH_C_LO: begin
          if (arg[CHAR_W-1:0] != CH_NUL) chars.push_back(arg[CHAR_W-1:0]);
        end
        CH_D_LO, CH_D_UP: begin
          // Build digits least significant first, so push to the front.
          do begin
            chars.push_front(CHAR_W'(CH_ZERO + v % 10));
            v = v / 10;
          end while (v != 0);
        end
        CH_X_LO, CH_X_UP: begin
          do begin
            nib = v[NIB_W-1:0];
            if (nib > 9) chars.push_front(CHAR_W'(CH_A_LO + nib - 10));
            else chars.push_front(CHAR_W'(CH_ZERO + nib));
            v = v >> NIB_W;
          end while (v != 0);
        end
        default: ;
      endcase
    end else if (ch == CH_PERCENT) begin
      percent_armed = 1'b1;
    end else begin
      chars.push_back(ch);
    end
    foreach (chars[k]) begin
      entry.chr  = chars[k];
      entry.last = (k == chars.size() - 1);
      expected_chars.push_back(entry);
    end
  endfunction

  // Offer one request and hold it until the block takes it. Push stays high
  // across back-to-back requests; it only drops while the sender idles.
  task automatic send_request(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    format_char <= ch;
    argument    <= arg;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_printout(ch, arg);
  endtask

  // Receiver: check each popped character against the oldest expectation,
  // then decide whether to pop in the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, got out_char %h last %b",
                   $time, out_char, last);
          error_count++;
        end else begin
          if (out_char !== expected_chars[0].chr) begin
            $display("%0t: out_char mismatch: expected %h, got %h",
                     $time, expected_chars[0].chr, out_char);
            error_count++;
          end
          if (last !== expected_chars[0].last) begin
            $display("%0t: last mismatch: expected %b, got %b",
                     $time, expected_chars[0].last, last);
            error_count++;
          end
          void'(expected_chars.pop_front());
        end
      end
      pop <= !holding && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold off the receiver for a fixed stretch when asked, so the command
  // queue and result register fill and full backs up into the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
      end
    end
  end

  // Pick an argument: full random a quarter of the time, otherwise zero, all ones,
  // single bits, short values and a zero low byte for %c.
  function automatic logic [ARG_W-1:0] pick_argument();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return ARG_W'(1) << $urandom_range(ARG_W - 1);
      3: return ARG_W'($urandom_range(15));
      4: return $urandom >> $urandom_range(ARG_W - 1);
      5: return $urandom & ~ARG_W'(8'hFF);
      default: return $urandom;
    endcase
  endfunction

  // Pick a conversion letter, one of the six the block knows.
  function automatic logic [CHAR_W-1:0] pick_conversion();
    case ($urandom_range(5))
      0: return CH_PERCENT;
      1: return CH_C_LO;
      2: return CH_D_LO;
      3: return CH_D_UP;
      4: return CH_X_LO;
      default: return CH_X_UP;
    endcase
  endfunction

  // Plain bytes at the edges of the range, an ordinary letter, and a NUL.
  task automatic test_plain_chars();
    send_request(8'h01, '0);
    send_request(8'hFF, '1);
    send_request(8'h41, $urandom);
    send_request(CH_NUL, $urandom);
    send_request(8'h7F, $urandom);
  endtask

  // Every conversion, with the extremes of the argument.
  task automatic test_conversions();
    send_request(CH_PERCENT, $urandom);
    send_request(CH_PERCENT, $urandom);
    send_request(CH_PERCENT, '0);
    send_request(CH_C_LO, 32'h1234_565A);
    send_request(CH_PERCENT, '0);
    send_request(CH_C_LO, 32'hFFFF_FF00);    // zero low byte prints nothing
    send_request(CH_PERCENT, '0);
    send_request(CH_D_LO, '0);
    send_request(CH_PERCENT, '0);
    send_request(CH_D_UP, '1);
    send_request(CH_PERCENT, '0);
    send_request(CH_X_LO, '0);
    send_request(CH_PERCENT, '0);
    send_request(CH_X_UP, '1);
    send_request(CH_PERCENT, '0);
    send_request(CH_D_LO, 32'd1000000000);
  endtask

  // End of string after '%', and conversions the block does not know.
  task automatic test_special_cases();
    send_request(CH_PERCENT, '0);
    send_request(CH_NUL, '1);
    send_request(CH_X_LO, '1);               // disarmed, so echoed as a plain 'x'
    send_request(CH_PERCENT, '0);
    send_request(8'h71, '1);                 // unknown conversion
    send_request(CH_PERCENT, '0);
    send_request(8'hFF, '1);
  endtask

  // Random traffic: mostly well-formed conversions with random arguments,
  // mixed with plain bytes, stray NULs and broken conversions.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int items);
    int sent;
    int pick;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request(CH_PERCENT, $urandom);
        send_request(pick_conversion(), pick_argument());
        sent += 2;
      end else if (pick < 53) begin
        // '%' followed by any byte: unknown conversions and NUL land here
        send_request(CH_PERCENT, $urandom);
        send_request(CHAR_W'($urandom_range(255)), $urandom);
        sent += 2;
      end else if (pick < 58) begin
        send_request(CH_NUL, $urandom);
        sent++;
      end else begin
        send_request(CHAR_W'($urandom_range(255, 1)), $urandom);
        sent++;
      end
    end
  endtask

  // Stall the receiver while the sender streams slow and fast requests
  // back to back; the sender must wait on full until the stall lifts.
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    for (i = 0; i < BURST_ITEMS / 2; i++) begin
      send_request(CH_PERCENT, $urandom);
      send_request((i % 2) ? CH_D_LO : CH_X_LO, pick_argument());
      send_request(CHAR_W'($urandom_range(255, 1)), $urandom);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    push        <= 1'b0;
    format_char <= CH_NUL;
    argument    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part runs with random idling on both sides.
    send_idle_pct = 33;
    recv_idle_pct = 68;
    test_plain_chars();
    test_conversions();
    test_special_cases();

    test_random_traffic(33, 68, PHASE_ITEMS);
    test_random_traffic(68, 33, PHASE_ITEMS);
    test_backpressure();
    test_random_traffic(0, 0, PHASE_ITEMS);

    // Drain: release push, wait for every owed character, then let the
    // back end run long enough to expose any stray output.
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
